[hdl/rde_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rde_pkg
// Types, constants and helpers shared by the radix digit emitter modules.
// ----------------------------------------------------------------------------
package rde_pkg;

  // Width of the value port and default for the used value bits
  localparam int VAL_W          = 31;
  localparam int VALUE_BITS_DEF = 31;

  // BCD word: ten decimal digits cover any 31-bit value
  localparam int BCD_W   = 40;
  localparam int DIG_DEC = BCD_W / 4;

  // Digit word carried to the back end: multiple of 12 (fits 1, 3 and 4 bit
  // digits) and no narrower than the BCD word
  localparam int WORD_W = 48;
  localparam int CNT_W  = $clog2(WORD_W + 1);

  localparam int QUEUE_DEPTH = 2;

  localparam logic [6:0] SYM_DIGIT_BASE = 7'd48;
  localparam logic [6:0] SYM_ALPHA_BASE = 7'd55;
  localparam logic [3:0] DEC_RADIX      = 4'd10;

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

  // One queued item: digits left-aligned in word, ndig digits to walk
  typedef struct packed {
    radix_t              mode;
    logic                empty;
    logic [CNT_W-1:0]    ndig;
    logic [WORD_W-1:0]   word;
  } rde_entry_t;

  function automatic logic [6:0] sym_of(input logic [3:0] d);
    logic [6:0] d7;
    d7 = {3'b000, d};
    return (d < DEC_RADIX) ? (d7 + SYM_DIGIT_BASE) : (d7 + SYM_ALPHA_BASE);
  endfunction

endpackage
`default_nettype wire

[hdl/rde_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rde_front
// Takes a beat, masks the value, runs the binary to BCD pass for decimal
// items and pushes a left-aligned digit word into the queue.
// ----------------------------------------------------------------------------
module rde_front import rde_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       in_op,
  input  wire logic [VAL_W-1:0] in_value,
  input  wire logic             q_full,
  output logic                  q_push,
  output rde_entry_t            q_entry
);

  localparam int EFF_BITS = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
  localparam int BC_W     = $clog2(EFF_BITS + 1);
  localparam int DIG_BIN  = EFF_BITS;
  localparam int DIG_OCT  = (EFF_BITS + 2) / 3;
  localparam int DIG_HEX  = (EFF_BITS + 3) / 4;
  localparam int SH_BIN   = WORD_W - DIG_BIN;
  localparam int SH_OCT   = WORD_W - 3 * DIG_OCT;
  localparam int SH_HEX   = WORD_W - 4 * DIG_HEX;
  localparam int SH_DEC   = WORD_W - BCD_W;

  front_state_t          state_r, state_nxt;
  radix_t                mode_r, mode_nxt;
  logic                  zero_r, zero_nxt;
  logic [EFF_BITS-1:0]   sr_r, sr_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [BC_W-1:0]       bc_r, bc_nxt;

  logic [EFF_BITS-1:0]   val_in;
  logic [BCD_W-1:0]      bcd_adj;
  logic [WORD_W-1:0]     value_ext;
  logic [WORD_W-1:0]     bcd_ext;

  assign val_in    = in_value[EFF_BITS-1:0];
  assign value_ext = {{(WORD_W - EFF_BITS){1'b0}}, sr_r};
  assign bcd_ext   = {{(WORD_W - BCD_W){1'b0}}, bcd_r};

  // Add-3 correction on every BCD digit before the shift
  always_comb begin
    for (int i = 0; i < DIG_DEC; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? (bcd_r[4*i +: 4] + 4'd3)
                                                     : bcd_r[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    zero_r <= zero_nxt;
    sr_r   <= sr_nxt;
    bcd_r  <= bcd_nxt;
    bc_r   <= bc_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    zero_nxt  = zero_r;
    sr_nxt    = sr_r;
    bcd_nxt   = bcd_r;
    bc_nxt    = bc_r;
    q_push    = 1'b0;
    busy      = (state_r != F_IDLE);

    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          mode_nxt  = radix_t'(in_op);
          sr_nxt    = val_in;
          zero_nxt  = (val_in == '0);
          bcd_nxt   = '0;
          bc_nxt    = BC_W'(EFF_BITS);
          state_nxt = ((radix_t'(in_op) == RADIX_DEC) && (val_in != '0)) ? F_CONV
                                                                         : F_PUSH;
        end
      end
      F_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], sr_r[EFF_BITS-1]};
        sr_nxt  = sr_r << 1;
        bc_nxt  = bc_r - 1'b1;
        if (bc_r == BC_W'(1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  // Queue entry: digits aligned so the top digit sits at the word's MSB
  always_comb begin
    q_entry.mode  = mode_r;
    q_entry.empty = zero_r;
    unique case (mode_r)
      RADIX_BIN: begin
        q_entry.ndig = CNT_W'(DIG_BIN);
        q_entry.word = value_ext << SH_BIN;
      end
      RADIX_OCT: begin
        q_entry.ndig = CNT_W'(DIG_OCT);
        q_entry.word = value_ext << SH_OCT;
      end
      RADIX_HEX: begin
        q_entry.ndig = CNT_W'(DIG_HEX);
        q_entry.word = value_ext << SH_HEX;
      end
      RADIX_DEC: begin
        q_entry.ndig = CNT_W'(DIG_DEC);
        q_entry.word = bcd_ext << SH_DEC;
      end
      default: begin
        q_entry.ndig = CNT_W'(DIG_BIN);
        q_entry.word = value_ext << SH_BIN;
      end
    endcase
    // zero value: a single empty result
    if (zero_r) begin
      q_entry.ndig = CNT_W'(1);
      q_entry.word = '0;
    end
  end

endmodule
`default_nettype wire

[hdl/rde_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rde_queue
// Small register FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module rde_queue import rde_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  rde_entry_t      push_data,
  output logic            full,
  input  wire logic       pop,
  output rde_entry_t      pop_data,
  output logic            empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  rde_entry_t          q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]   count_r, count_nxt;

  assign full     = (count_r == CNT_QW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

[hdl/rde_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rde_back
// Walks the queued digit word from the top, one digit a cycle, drops
// leading zeros and registers each result beat.
// ----------------------------------------------------------------------------
module rde_back import rde_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_empty,
  input  rde_entry_t  q_entry,
  output logic        q_pop,
  output logic        out_strobe,
  output logic [3:0]  out_digit,
  output logic [6:0]  out_symbol,
  output logic        out_empty_res,
  output logic        out_last
);

  back_state_t         state_r, state_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  radix_t              mode_r, mode_nxt;
  logic                empty_r, empty_nxt;
  logic                seen_r, seen_nxt;

  logic                strobe_r, strobe_nxt;
  logic [3:0]          digit_r, digit_nxt;
  logic [6:0]          symbol_r, symbol_nxt;
  logic                oempty_r, oempty_nxt;
  logic                last_r, last_nxt;

  logic [3:0]          dig;
  logic [WORD_W-1:0]   word_shift;
  logic                emit;
  logic                do_load;

  // top digit of the word and the word moved on by one digit
  always_comb begin
    unique case (mode_r)
      RADIX_BIN: begin
        dig        = {3'b000, word_r[WORD_W-1]};
        word_shift = word_r << 1;
      end
      RADIX_OCT: begin
        dig        = {1'b0, word_r[WORD_W-1 -: 3]};
        word_shift = word_r << 3;
      end
      RADIX_DEC, RADIX_HEX: begin
        dig        = word_r[WORD_W-1 -: 4];
        word_shift = word_r << 4;
      end
      default: begin
        dig        = word_r[WORD_W-1 -: 4];
        word_shift = word_r << 4;
      end
    endcase
  end

  assign emit = empty_r || seen_r || (dig != 4'd0) || (cnt_r == CNT_W'(1));

  always_comb begin
    state_nxt  = state_r;
    word_nxt   = word_r;
    cnt_nxt    = cnt_r;
    mode_nxt   = mode_r;
    empty_nxt  = empty_r;
    seen_nxt   = seen_r;
    strobe_nxt = 1'b0;
    digit_nxt  = digit_r;
    symbol_nxt = symbol_r;
    oempty_nxt = oempty_r;
    last_nxt   = last_r;
    do_load    = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        do_load = !q_empty;
      end
      B_RUN: begin
        strobe_nxt = emit;
        digit_nxt  = dig;
        // zero value: the empty beat carries no character
        symbol_nxt = empty_r ? 7'd0 : sym_of(dig);
        oempty_nxt = empty_r;
        last_nxt   = (cnt_r == CNT_W'(1));
        seen_nxt   = seen_r | (dig != 4'd0);
        word_nxt   = word_shift;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = B_IDLE;
          do_load   = !q_empty;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    q_pop = do_load;
    if (do_load) begin
      word_nxt  = q_entry.word;
      cnt_nxt   = q_entry.ndig;
      mode_nxt  = q_entry.mode;
      empty_nxt = q_entry.empty;
      seen_nxt  = 1'b0;
      state_nxt = B_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r   <= word_nxt;
    cnt_r    <= cnt_nxt;
    mode_r   <= mode_nxt;
    empty_r  <= empty_nxt;
    seen_r   <= seen_nxt;
    digit_r  <= digit_nxt;
    symbol_r <= symbol_nxt;
    oempty_r <= oempty_nxt;
    last_r   <= last_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_digit     = digit_r;
  assign out_symbol    = symbol_r;
  assign out_empty_res = oempty_r;
  assign out_last      = last_r;

endmodule
`default_nettype wire

[hdl/radix_digit_emitter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radix_digit_emitter
// Emits the digits of a value in binary, octal, decimal or hex, most
// significant first, one result beat per digit, leading zeros dropped.
// ----------------------------------------------------------------------------
// Order: the front end takes the start beat, runs the BCD pass for nonzero
//   decimal items (one bit per cycle) and pushes the digit word into the queue;
//   the back end walks it, and every leading zero slot delays the first beat,
//   as does waiting behind a queued item. The back end walks 31 / 11 / 8 / 10
//   digit slots per item (bin / oct / hex / dec, for 31 value bits), 1 for a
//   zero value; the front end overlaps with the digit walk through a two-entry
//   queue. Busy is high while the front end holds an item.
// Reset: synchronous, active low; clears both state machines, the queue
//   and the strobe. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module radix_digit_emitter import rde_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input beat: taken when start is high and busy is low
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       in_op,
  input  wire logic [VAL_W-1:0] in_value,
  // result beat: valid for the one cycle that out_strobe is high
  output logic                  out_strobe,
  output logic [3:0]            out_digit,
  output logic [6:0]            out_symbol,
  output logic                  out_empty_res,
  output logic                  out_last
);

  // front -> queue
  logic        q_push;
  logic        q_full;
  rde_entry_t  q_in;
  // queue -> back
  logic        q_pop;
  logic        q_empty;
  rde_entry_t  q_out;

  // Front: masks the value to VALUE_BITS, runs the shift-and-add-3 pass for
  // decimal, and aligns the digit word so the top digit is at the MSB.
  rde_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_op    (in_op),
    .in_value (in_value),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  // Decouples the BCD pass from the digit walk so both can run at once.
  rde_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // Back: one digit slot per cycle; leading zero slots are walked but give
  // no beat. The final slot always gives a beat with out_last set.
  rde_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_entry       (q_out),
    .q_pop         (q_pop),
    .out_strobe    (out_strobe),
    .out_digit     (out_digit),
    .out_symbol    (out_symbol),
    .out_empty_res (out_empty_res),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

[tb/radix_digit_emitter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_emitter_test
// Self-checking bench for the radix digit emitter. Values are fed in binary,
// octal, decimal and hex mode: a directed set first, then random beats with
// random idle bursts. A scoreboard works out the digit string of every
// accepted value and checks each result beat against it, field by field.
// ----------------------------------------------------------------------------
module radix_digit_emitter_test;
  import rde_pkg::*;

  localparam int VALUE_BITS   = VALUE_BITS_DEF;
  localparam int RANDOM_ITEMS = 380;
  // Random beats at the end that run back to back, with no idling
  localparam int BURST_TAIL   = 60;
  // Longest quiet stretch of a correct run is a decimal pass plus an idle
  // burst; this limit is many times that
  localparam int QUIET_LIMIT  = 2000;
  // Cycles to watch for stray beats once nothing is owed any more
  localparam int TAIL_CYCLES  = VALUE_BITS + 40;
  localparam int MAX_DIGITS   = 31;

  // One expected result beat
  typedef struct {
    logic [3:0] digit;
    logic [6:0] symbol;
    logic       empty_res;
    logic       last;
  } digit_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: converts each accepted value into the digit beats it owes and
  // checks the emitted beats against them in order.
  // --------------------------------------------------------------------------
  class digit_scoreboard;
    digit_beat_t      owed[$];
    // Own copy of the block's state, as left by the last accepted beat
    logic [VAL_W-1:0] residual;
    radix_t           radix_mode;
    int               errors;
    int               items;
    int               zeros;
    int               beats;
    int               per_radix[4];

    function new();
      residual   = '0;
      radix_mode = RADIX_BIN;
      errors     = 0;
      items      = 0;
      zeros      = 0;
      beats      = 0;
      foreach (per_radix[i]) per_radix[i] = 0;
    endfunction

    // An input beat was accepted: queue the digits it will produce
    function void note_item(radix_t radix, logic [VAL_W-1:0] value);
      logic [63:0] v;
      logic [63:0] dmask;
      logic [3:0]  ds[MAX_DIGITS + 1];
      int          n;
      int          k;
      int          shift;
      digit_beat_t b;
      v = {{(64 - VAL_W){1'b0}}, value};
      if (VALUE_BITS < 63) v = v & ((64'd1 << VALUE_BITS) - 64'd1);
      residual   = v[VAL_W-1:0];
      radix_mode = radix;
      items++;
      per_radix[radix]++;
      n = 0;
      // Zero: one beat flagged empty, digit and symbol both zero
      if (v == 64'd0) begin
        zeros++;
        b.digit     = '0;
        b.symbol    = '0;
        b.empty_res = 1'b1;
        b.last      = 1'b1;
        owed.push_back(b);
        return;
      end
      if (radix == RADIX_DEC) begin
        while (v != 64'd0 && n < DIG_DEC) begin
          ds[n] = 4'(v % DEC_RADIX);
          v     = v / DEC_RADIX;
          n++;
        end
      end else begin
        shift = (radix == RADIX_BIN) ? 1 : (radix == RADIX_OCT) ? 3 : 4;
        dmask = (64'd1 << shift) - 64'd1;
        while (v != 64'd0 && n < MAX_DIGITS) begin
          ds[n] = 4'(v & dmask);
          v     = v >> shift;
          n++;
        end
      end
      // Collected least significant first; emitted most significant first
      for (k = 0; k < n; k++) begin
        b.digit     = ds[n - 1 - k];
        b.symbol    = (b.digit < DEC_RADIX) ? ({3'b000, b.digit} + SYM_DIGIT_BASE)
                                            : ({3'b000, b.digit} + SYM_ALPHA_BASE);
        b.empty_res = 1'b0;
        b.last      = (k == n - 1);
        owed.push_back(b);
      end
    endfunction

    // A result beat was seen: compare with the oldest owed beat
    function void check_beat(logic [3:0] digit, logic [6:0] symbol,
                             logic empty_res, logic last);
      digit_beat_t e;
      beats++;
      if (owed.size() == 0) begin
        $error("result beat with nothing owed: digit %0d symbol %0d empty %0b last %0b",
               digit, symbol, empty_res, last);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (digit !== e.digit) begin
        $error("digit: expected %0d, actual %0d", e.digit, digit);
        errors++;
      end
      if (symbol !== e.symbol) begin
        $error("symbol: expected %0d, actual %0d", e.symbol, symbol);
        errors++;
      end
      if (empty_res !== e.empty_res) begin
        $error("empty_res: expected %0b, actual %0b", e.empty_res, empty_res);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0b, actual %0b", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic             clk      = 1'b0;
  logic             rst_n    = 1'b0;
  logic             start    = 1'b0;
  logic [1:0]       in_op    = RADIX_BIN;
  logic [VAL_W-1:0] in_value = '0;
  logic             busy;
  logic             out_strobe;
  logic [3:0]       out_digit;
  logic [6:0]       out_symbol;
  logic             out_empty_res;
  logic             out_last;

  digit_scoreboard  sb;
  int               quiet_cycles = 0;

  always #5 clk = ~clk;

  radix_digit_emitter #(
    .VALUE_BITS(VALUE_BITS)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_value     (in_value),
    .out_strobe   (out_strobe),
    .out_digit    (out_digit),
    .out_symbol   (out_symbol),
    .out_empty_res(out_empty_res),
    .out_last     (out_last)
  );

  // Result side: the receiver never stalls, so every strobe is a beat.
  // Sampled at the edge, i.e. the values held through the cycle just ended.
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_beat(out_digit, out_symbol, out_empty_res, out_last);
  end

  // Watchdog: any cycle with neither an input nor a result beat counts as
  // quiet; too many in a row means the block has hung.
  always @(posedge clk) begin
    if (!rst_n || out_strobe || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks. All are entered and left just after a rising edge, and
  // start is only changed by one of them per edge.
  // --------------------------------------------------------------------------

  // Present one beat and hold it until the block takes it. Start is left
  // high, so back to back beats need no second assignment in one step.
  task automatic send_item(radix_t radix, logic [VAL_W-1:0] value);
    start    <= 1'b1;
    in_op    <= radix;
    in_value <= value;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(radix, value);
  endtask

  // Idle burst; the payload wanders meanwhile to show it is ignored
  task automatic idle_burst(int cycles);
    start    <= 1'b0;
    in_op    <= 2'($urandom);
    in_value <= VAL_W'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every owed beat has come
  task automatic wait_all_digits();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Values of random length, so the digit count varies; now and then the
  // extremes
  function automatic logic [VAL_W-1:0] random_value();
    int               sel;
    int               len;
    logic [VAL_W-1:0] r;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return {VAL_W{1'b1}};
    len = $urandom_range(1, VAL_W);
    r   = VAL_W'($urandom);
    return r >> (VAL_W - len);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int i;
    int r;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: in every radix a zero value (the empty case), a single
    // digit one, and the widest value, which sets every value bit and
    // gives the longest digit string (31 binary digits)
    for (r = 0; r < 4; r++) begin
      send_item(radix_t'(r), '0);
      send_item(radix_t'(r), VAL_W'(1));
      send_item(radix_t'(r), {VAL_W{1'b1}});
    end
    // Digit boundaries: 9/10 in decimal, 15/16 in hex, eight in octal
    send_item(RADIX_DEC, VAL_W'(9));
    send_item(RADIX_DEC, VAL_W'(10));
    send_item(RADIX_HEX, VAL_W'(15));
    send_item(RADIX_HEX, VAL_W'(16));
    send_item(RADIX_OCT, VAL_W'(8));
    // Zero digits in the middle and at the end must still be emitted
    send_item(RADIX_DEC, VAL_W'(1000000000));
    send_item(RADIX_DEC, VAL_W'(1000000001));
    send_item(RADIX_HEX, VAL_W'('h1000_0000));
    send_item(RADIX_OCT, VAL_W'('h4000_0000));
    // Alternating bit patterns in binary
    send_item(RADIX_BIN, VAL_W'('h5555_5555));
    send_item(RADIX_BIN, VAL_W'('h2AAA_AAAA));

    // Let the block run dry before the random part
    wait_all_digits();

    // Random part: idle bursts on the sender side, none in the tail
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i < RANDOM_ITEMS - BURST_TAIL && $urandom_range(0, 3) == 0)
        idle_burst($urandom_range(1, 9));
      if (i == RANDOM_ITEMS / 2) wait_all_digits();
      send_item(radix_t'($urandom_range(0, 3)), random_value());
    end

    // Drain, then watch a while longer for stray beats
    wait_all_digits();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d values (bin %0d, oct %0d, dec %0d, hex %0d), %0d of them zero;",
             sb.items, sb.per_radix[RADIX_BIN], sb.per_radix[RADIX_OCT],
             sb.per_radix[RADIX_DEC], sb.per_radix[RADIX_HEX], sb.zeros);
    $display("%0d digit beats were checked, %0d fields disagreed.", sb.beats, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/rde_pkg.sv
hdl/rde_front.sv
hdl/rde_queue.sv
hdl/rde_back.sv
hdl/radix_digit_emitter.sv
tb/radix_digit_emitter_test.sv
